[design/msd_pkg.sv]
// Shared constants and types for the marker stream demultiplexer.
`default_nettype none

package msd_pkg;

  localparam int MARKER_LEN  = 11;
  localparam int MC_W        = $clog2(MARKER_LEN);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] MARK_OPEN = 8'h5B;  // '['

  // "[BUF/BEGIN]"
  localparam logic [7:0] MARK_ON [MARKER_LEN] = '{
    8'h5B, 8'h42, 8'h55, 8'h46, 8'h2F, 8'h42, 8'h45, 8'h47, 8'h49, 8'h4E, 8'h5D
  };
  // "[BUF/CLOSE]"
  localparam logic [7:0] MARK_OFF [MARKER_LEN] = '{
    8'h5B, 8'h42, 8'h55, 8'h46, 8'h2F, 8'h43, 8'h4C, 8'h4F, 8'h53, 8'h45, 8'h5D
  };

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_FLUSH,
    FR_PEND
  } front_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_capture;
    logic       last_of_run;
  } result_t;

endpackage

`default_nettype wire

[design/marker_stream_demux_unit.sv]
// Top level of the marker stream demultiplexer.
//
// Slave side (s_tvalid/s_tready/s_tdata) takes one received serial byte per item.
// Master side (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) gives the bytes passed
// on: m_tuser is 1 for the capture channel, 0 for text, m_tlast marks the final
// item caused by one input byte. "[BUF/BEGIN]" and "[BUF/CLOSE]" switch capture
// on and off and never appear on the output; an input byte that continues either
// marker is held back and gives no item.
// A plain byte is pushed into the result queue as it is taken and then moves on
// to the output register. A byte that breaks a partial marker holds the front end
// while the held bytes are read out of the hold register file into the queue one
// per cycle while the queue has room, and then passes the byte itself on unless it
// is a fresh '[', which opens a new candidate.
// A small result queue and the output register sit between the two ends, so the
// front keeps taking bytes while results wait; s_tready drops when the queue is
// full or a flush is running. When the receiver stalls, m_* hold their item.
// Synchronous reset empties the queue, selects the text channel and forgets any
// partial marker; no clearing pass is needed.
`default_nettype none

module marker_stream_demux_unit
  import msd_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // rx_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic [0:0]      m_tuser,   // to_capture
  output logic            m_tlast    // last_of_run
);

  logic    full;
  logic    push;
  result_t push_data;

  msd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  msd_back #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

[design/msd_front.sv]
// Front end: takes bytes, tracks marker matches and capture mode, queues results.
`default_nettype none

module msd_front
  import msd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       full,
  output logic            push,
  output result_t         push_data
);

  front_state_t state, state_next;

  logic [MC_W-1:0] match_count, match_count_next;
  logic [MC_W-1:0] idx, idx_next;
  logic            on_ok, on_ok_next;
  logic            off_ok, off_ok_next;
  logic            capture_mode, capture_mode_next;
  logic [7:0]      pend_byte, pend_byte_next;

  logic [7:0]      held [MARKER_LEN];
  logic            held_we;
  logic [MC_W-1:0] held_wa;
  logic [7:0]      held_wd;

  logic            accept;
  logic            hit_on, hit_off;
  logic            flush_end;

  assign s_tready  = (state == FR_IDLE) && !full;
  assign accept    = s_tvalid && s_tready;
  assign hit_on    = (s_tdata == MARK_ON[match_count]);
  assign hit_off   = (s_tdata == MARK_OFF[match_count]);
  assign flush_end = (idx == match_count - MC_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FR_IDLE;
      match_count  <= '0;
      capture_mode <= 1'b0;
    end else begin
      state        <= state_next;
      match_count  <= match_count_next;
      capture_mode <= capture_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    idx       <= idx_next;
    on_ok     <= on_ok_next;
    off_ok    <= off_ok_next;
    pend_byte <= pend_byte_next;
    if (held_we) begin
      held[held_wa] <= held_wd;
    end
  end

  always_comb begin
    state_next        = state;
    match_count_next  = match_count;
    idx_next          = idx;
    on_ok_next        = on_ok;
    off_ok_next       = off_ok;
    capture_mode_next = capture_mode;
    pend_byte_next    = pend_byte;
    held_we           = 1'b0;
    held_wa           = '0;
    held_wd           = s_tdata;
    push              = 1'b0;
    push_data         = '{out_byte: s_tdata, to_capture: capture_mode, last_of_run: 1'b1};

    unique case (state)
      FR_IDLE: begin
        if (accept) begin
          if (match_count != '0 && (hit_on || hit_off)) begin
            held_we     = 1'b1;
            held_wa     = match_count;
            on_ok_next  = on_ok && hit_on;
            off_ok_next = off_ok && hit_off;
            if (match_count == MC_W'(MARKER_LEN - 1)) begin
              // full sequence: a mixed one leaves the mode alone
              if (on_ok && hit_on) begin
                capture_mode_next = 1'b1;
              end else if (off_ok && hit_off) begin
                capture_mode_next = 1'b0;
              end
              match_count_next = '0;
            end else begin
              match_count_next = match_count + MC_W'(1);
            end
          end else if (match_count != '0) begin
            pend_byte_next = s_tdata;
            idx_next       = '0;
            state_next     = FR_FLUSH;
          end else if (s_tdata == MARK_OPEN) begin
            held_we          = 1'b1;
            held_wa          = '0;
            match_count_next = MC_W'(1);
            on_ok_next       = 1'b1;
            off_ok_next      = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
      end

      FR_FLUSH: begin
        push_data = '{out_byte: held[idx], to_capture: capture_mode,
                      last_of_run: flush_end && (pend_byte == MARK_OPEN)};
        if (!full) begin
          push = 1'b1;
          if (flush_end) begin
            if (pend_byte == MARK_OPEN) begin
              // the mismatching byte opens a fresh candidate
              held_we          = 1'b1;
              held_wa          = '0;
              held_wd          = pend_byte;
              match_count_next = MC_W'(1);
              on_ok_next       = 1'b1;
              off_ok_next      = 1'b1;
              state_next       = FR_IDLE;
            end else begin
              state_next = FR_PEND;
            end
          end else begin
            idx_next = idx + MC_W'(1);
          end
        end
      end

      FR_PEND: begin
        push_data = '{out_byte: pend_byte, to_capture: capture_mode, last_of_run: 1'b1};
        if (!full) begin
          push             = 1'b1;
          match_count_next = '0;
          state_next       = FR_IDLE;
        end
      end

      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/msd_back.sv]
// Back end: result queue with a registered output stage on the master side.
`default_nettype none

module msd_back
  import msd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire result_t    push_data,
  output logic            full,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,  // out_byte
  output logic [0:0]      m_tuser,  // to_capture
  output logic            m_tlast   // last_of_run
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  result_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          pop;
  result_t       out_reg;

  assign full     = (count == CW'(DEPTH));
  assign pop      = (count != '0) && (!m_tvalid || m_tready);
  assign m_tdata  = out_reg.out_byte;
  assign m_tuser  = out_reg.to_capture;
  assign m_tlast  = out_reg.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (pop) begin
      out_reg <= mem[rd_ptr];
    end
  end

endmodule

`default_nettype wire

[design/msd_checker.sv]
// Port-level checks for the marker stream demultiplexer, bound to the top level.
`default_nettype none

module msd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic [0:0] m_tuser,
  input wire logic       m_tlast
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an item that is not last in its run is a flushed marker byte
  a_flush_bytes: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |->
      (m_tdata == 8'h5B || m_tdata == 8'h42 || m_tdata == 8'h55 ||
       m_tdata == 8'h46 || m_tdata == 8'h2F || m_tdata == 8'h45 ||
       m_tdata == 8'h47 || m_tdata == 8'h49 || m_tdata == 8'h4E ||
       m_tdata == 8'h43 || m_tdata == 8'h4C || m_tdata == 8'h4F ||
       m_tdata == 8'h53))
    else $error("non-final item is not a marker byte");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("output item withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      ($stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
    else $error("output item changed while stalled");

endmodule

bind marker_stream_demux_unit msd_checker u_msd_checker (.*);

`default_nettype wire

[sim/marker_stream_demux_unit_tb.sv]
// Self-checking testbench for marker_stream_demux_unit: byte stream in, channel-tagged bytes out.
`default_nettype none

import msd_pkg::*;

class demux_scoreboard;
  localparam logic [8*MARKER_LEN-1:0] TAG_ON  = "[BUF/BEGIN]";
  localparam logic [8*MARKER_LEN-1:0] TAG_OFF = "[BUF/CLOSE]";

  result_t     expected_q[$];
  int unsigned mismatches;
  int          held_len;
  logic [7:0]  held [MARKER_LEN];
  logic        capture_on;

  function new();
    mismatches = 0;
    held_len   = 0;
    capture_on = 1'b0;
  endfunction

  // off selects the close tag; character idx counted from the '['
  static function logic [7:0] tag_char(bit off, int idx);
    logic [8*MARKER_LEN-1:0] tag;
    tag = off ? TAG_OFF : TAG_ON;
    return tag[8*(MARKER_LEN-1-idx) +: 8];
  endfunction

  function bit held_is(bit off);
    for (int i = 0; i < MARKER_LEN; i++) begin
      if (held[i] != tag_char(off, i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void push_byte(logic [7:0] v);
    result_t r;
    r.out_byte    = v;
    r.to_capture  = capture_on;
    r.last_of_run = 1'b0;
    expected_q.push_back(r);
  endfunction

  // works out the items one accepted input byte gives
  function void note_byte(logic [7:0] b);
    int size_before;
    size_before = expected_q.size();
    if (held_len != 0) begin
      if (b == tag_char(1'b0, held_len) || b == tag_char(1'b1, held_len)) begin
        held[held_len] = b;
        held_len++;
        if (held_len == MARKER_LEN) begin
          // mixed letters leave the mode alone
          if (held_is(1'b0)) capture_on = 1'b1;
          else if (held_is(1'b1)) capture_on = 1'b0;
          held_len = 0;
        end
        return;
      end
      for (int i = 0; i < held_len; i++) push_byte(held[i]);
      held_len = 0;
    end
    if (b == tag_char(1'b0, 0)) begin
      held[0]  = b;
      held_len = 1;
    end else begin
      push_byte(b);
    end
    if (expected_q.size() > size_before)
      expected_q[expected_q.size()-1].last_of_run = 1'b1;
  endfunction

  function void check_result(logic [7:0] d, logic cap, logic last);
    result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t: unexpected item data %02h capture %0b last %0b", $time, d, cap, last);
      return;
    end
    e = expected_q.pop_front();
    if (e.out_byte !== d) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t: out_byte expected %02h actual %02h", $time, e.out_byte, d);
    end
    if (e.to_capture !== cap) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t: to_capture expected %0b actual %0b", $time, e.to_capture, cap);
    end
    if (e.last_of_run !== last) begin
      mismatches++;
      if (mismatches <= 30)
        $display("%0t: last_of_run expected %0b actual %0b", $time, e.last_of_run, last);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module marker_stream_demux_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_OFF_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // rx_byte
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // out_byte
  logic [0:0] m_tuser;           // to_capture
  logic       m_tlast;           // last_of_run

  demux_scoreboard sb;
  int  sent_count = 0;
  bit  no_idle = 1'b0;
  bit  hold_request = 1'b0;
  bit  hold_done = 1'b0;

  marker_stream_demux_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0], m_tlast);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (no_idle) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 26) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    sb.note_byte(b);
    sent_count++;
  endtask

  task automatic send_tag(input bit off, input int len);
    for (int i = 0; i < len; i++) send_byte(sb.tag_char(off, i));
  endtask

  // letters picked from either tag at each position
  task automatic send_mixed_tag();
    for (int i = 0; i < MARKER_LEN; i++)
      send_byte(sb.tag_char(bit'($urandom_range(1)), i));
  endtask

  initial begin
    int pick;
    int target;
    int wait_cycles;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes, flush with a fresh '[', a tag, and the longest flush
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte("[");
    send_byte("[");
    send_byte("x");
    send_tag(1'b0, MARKER_LEN);
    send_byte("a");
    send_tag(1'b0, MARKER_LEN - 1);
    send_byte("!");

    target = sent_count + RANDOM_ITEMS;
    while (sent_count < target) begin
      if (!hold_done && sent_count >= target - RANDOM_ITEMS + 100) begin
        hold_request = 1'b1;
        hold_done    = 1'b1;
      end
      no_idle = (sent_count >= target - 300) && (sent_count < target - 180);
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_tag(1'b0, MARKER_LEN);
      end else if (pick < 40) begin
        send_tag(1'b1, MARKER_LEN);
      end else if (pick < 50) begin
        send_mixed_tag();
      end else if (pick < 75) begin
        // broken tag: prefix then an arbitrary byte
        send_tag(bit'($urandom_range(1)), $urandom_range(1, MARKER_LEN - 1));
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    wait_cycles = 40;
    repeat (wait_cycles) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/msd_pkg.sv
design/msd_front.sv
design/msd_back.sv
design/marker_stream_demux_unit.sv
design/msd_checker.sv
sim/marker_stream_demux_unit_tb.sv
